// ----- rtl/hsj_pkg.sv -----
// hsj_pkg: shared widths, register codes and window types of the heat stencil step
// no dependencies; imported by every module of the block
package hsj_pkg;

  localparam int VALUE_W        = 32;
  localparam int GRID_SIZE_W    = 11;
  localparam int COEFF_W        = 15;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int MAX_GRID_DEFAULT = 1024;
  localparam int MIN_GRID       = 3;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = GRID_SIZE_W'(128);
  localparam logic [COEFF_W-1:0]     COEFF_RESET     = COEFF_W'(15729);

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF     = CFG_INDEX_W'(1);

  typedef struct packed {
    logic border;
    logic last_row;
    logic done;
  } flags_t;

  // one 5-point window plus what the back end needs to shape the results
  typedef struct packed {
    logic signed [VALUE_W-1:0] c;
    logic signed [VALUE_W-1:0] l;
    logic signed [VALUE_W-1:0] r;
    logic signed [VALUE_W-1:0] u;
    logic signed [VALUE_W-1:0] d;
    flags_t                    flags;
  } window_t;

endpackage

// ----- rtl/hsj_front.sv -----
// hsj_front: accepts cells, tracks the grid position and keeps both row buffers
// depends on hsj_pkg; pushes complete windows into hsj_queue
module hsj_front #(
  parameter int MAX_GRID = hsj_pkg::MAX_GRID_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hsj_pkg::GRID_SIZE_W-1:0]      grid_size,
  input  logic                                 restart,
  input  logic                                 cell_valid,
  input  logic signed [hsj_pkg::VALUE_W-1:0]   cell_value,
  output logic                                 cell_stall,
  output logic                                 q_push,
  output hsj_pkg::window_t                     q_data,
  input  logic                                 q_full
);
  import hsj_pkg::*;

  localparam int AW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int NW = $clog2(MAX_GRID + 1);

  logic signed [VALUE_W-1:0] row_one_back [MAX_GRID];
  logic signed [VALUE_W-1:0] row_two_back [MAX_GRID];

  logic [NW-1:0] n_active;
  logic [AW-1:0] nm1;
  logic [AW-1:0] pos_i;
  logic [AW-1:0] pos_j;

  // stage a: accepted cell and its position
  logic                      a_valid;
  logic signed [VALUE_W-1:0] a_down;
  logic [AW-1:0]             a_j;
  logic [AW-1:0]             a_raddr;
  logic                      a_emit;
  flags_t                    a_flags;

  // stage b: window assembled from the buffer reads
  logic                      b_valid;
  logic signed [VALUE_W-1:0] b_down;
  logic [AW-1:0]             b_j;
  logic                      b_emit;
  flags_t                    b_flags;
  logic signed [VALUE_W-1:0] b_c;
  logic signed [VALUE_W-1:0] b_left;
  logic signed [VALUE_W-1:0] rd_right;
  logic signed [VALUE_W-1:0] rd_up;

  logic cell_accept;
  logic a_to_b;
  logic b_retire;

  always_comb begin
    if (32'(grid_size) < 32'(MIN_GRID)) begin
      n_active = NW'(MIN_GRID);
    end else if (32'(grid_size) > 32'(MAX_GRID)) begin
      n_active = NW'(MAX_GRID);
    end else begin
      n_active = NW'(grid_size);
    end
    nm1 = AW'(n_active - NW'(1));
  end

  always_comb begin
    b_retire    = b_valid && (!b_emit || !q_full);
    a_to_b      = a_valid && (!b_valid || b_retire);
    cell_stall  = a_valid && !a_to_b;
    cell_accept = cell_valid && !cell_stall;
    q_push      = b_valid && b_emit && !q_full;
    q_data      = '{c: b_c, l: b_left, r: rd_right, u: rd_up, d: b_down, flags: b_flags};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_i <= '0;
      pos_j <= '0;
    end else if (cell_accept) begin
      if (pos_j == nm1) begin
        pos_j <= '0;
        pos_i <= (pos_i == nm1) ? '0 : pos_i + AW'(1);
      end else begin
        pos_j <= pos_j + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cell_accept) begin
      a_valid <= 1'b1;
    end else if (a_to_b) begin
      a_valid <= 1'b0;
    end
  end

  // at the last column the right tap is unused, so that slot fetches the
  // centre of column zero for the next row
  always_ff @(posedge clk) begin
    if (cell_accept) begin
      a_down          <= cell_value;
      a_j             <= pos_j;
      a_raddr         <= (pos_j == nm1) ? '0 : pos_j + AW'(1);
      a_emit          <= (pos_i != '0);
      a_flags.border  <= (pos_i == AW'(1)) || (pos_j == '0) || (pos_j == nm1);
      a_flags.last_row <= (pos_i == nm1);
      a_flags.done    <= (pos_j == nm1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_to_b) begin
      b_valid <= 1'b1;
    end else if (b_retire) begin
      b_valid <= 1'b0;
    end
  end

  // window slides one column per transfer: right becomes centre becomes left
  always_ff @(posedge clk) begin
    if (a_to_b) begin
      b_down  <= a_down;
      b_j     <= a_j;
      b_emit  <= a_emit;
      b_flags <= a_flags;
      b_c     <= rd_right;
      b_left  <= b_c;
    end
  end

  always_ff @(posedge clk) begin
    if (a_to_b) begin
      rd_right <= row_one_back[a_raddr];
    end
    if (b_retire) begin
      row_one_back[b_j] <= b_down;
    end
  end

  always_ff @(posedge clk) begin
    if (a_to_b) begin
      rd_up <= row_two_back[a_j];
    end
    if (b_retire) begin
      row_two_back[b_j] <= b_c;
    end
  end

endmodule

// ----- rtl/hsj_queue.sv -----
// hsj_queue: short window queue between front and back end
// depends on hsj_pkg for the window type and depth
module hsj_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hsj_pkg::window_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output hsj_pkg::window_t head_data
);
  import hsj_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  window_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_comb begin
    full       = (count == CW'(QUEUE_DEPTH));
    head_valid = (count != '0);
    head_data  = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/hsj_back.sv -----
// hsj_back: stencil arithmetic pipeline and result register
// depends on hsj_pkg; pops windows from hsj_queue
module hsj_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [hsj_pkg::COEFF_W-1:0]        coeff,
  input  logic                               q_valid,
  input  hsj_pkg::window_t                   q_data,
  output logic                               q_pop,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [hsj_pkg::VALUE_W-1:0] new_value,
  output logic                               run_last,
  output logic                               grid_done
);
  import hsj_pkg::*;

  localparam int SUM_W   = VALUE_W + 4;
  localparam int PROD_W  = SUM_W + COEFF_W + 1;
  localparam int FRAC_W  = 16;
  localparam int DELTA_W = PROD_W - FRAC_W;
  localparam int RES_W   = DELTA_W + 1;

  logic                      p1_valid;
  logic signed [SUM_W-1:0]   p1_sum;
  logic signed [VALUE_W-1:0] p1_c;
  logic signed [VALUE_W-1:0] p1_d;
  flags_t                    p1_flags;

  logic                      p2_valid;
  logic signed [PROD_W-1:0]  p2_prod;
  logic signed [VALUE_W-1:0] p2_c;
  logic signed [VALUE_W-1:0] p2_d;
  flags_t                    p2_flags;

  logic                      p3_valid;
  logic signed [DELTA_W-1:0] p3_delta;
  logic signed [VALUE_W-1:0] p3_c;
  logic signed [VALUE_W-1:0] p3_d;
  flags_t                    p3_flags;

  logic                      out_second;
  logic signed [VALUE_W-1:0] hold_d;
  logic                      hold_done;

  logic                      result_accept;
  logic                      out_free;
  logic                      p3_load;
  logic                      p3_take;
  logic                      p2_take;
  logic                      p1_take;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [RES_W-1:0]   res_wide;
  logic signed [VALUE_W-1:0] res_sat;
  logic signed [VALUE_W-1:0] first_value;

  always_comb begin
    result_accept = result_valid && !result_stall;
    out_free      = !result_valid || (result_accept && !out_second);
    p3_load       = p3_valid && out_free;
    p3_take       = !p3_valid || p3_load;
    p2_take       = !p2_valid || (p3_take);
    p1_take       = !p1_valid || (p2_take);
    q_pop         = q_valid && p1_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      if (p1_take) begin
        p1_valid <= q_valid;
      end
      if (p2_take) begin
        p2_valid <= p1_valid;
      end
      if (p3_take) begin
        p3_valid <= p2_valid;
      end
    end
  end

  // laplacian sum stays exact
  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_sum <= SUM_W'(q_data.l) + SUM_W'(q_data.r) + SUM_W'(q_data.u)
              + SUM_W'(q_data.d) - (SUM_W'(q_data.c) <<< 2);
      p1_c     <= q_data.c;
      p1_d     <= q_data.d;
      p1_flags <= q_data.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p2_take) begin
      p2_prod  <= PROD_W'(p1_sum) * PROD_W'($signed({1'b0, coeff}));
      p2_c     <= p1_c;
      p2_d     <= p1_d;
      p2_flags <= p1_flags;
    end
  end

  // round half up, then floor to q16.16
  assign rounded = p2_prod + PROD_W'(1 << (FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (p2_valid && p3_take) begin
      p3_delta <= rounded[PROD_W-1:FRAC_W];
      p3_c     <= p2_c;
      p3_d     <= p2_d;
      p3_flags <= p2_flags;
    end
  end

  always_comb begin
    res_wide = RES_W'(p3_c) + RES_W'(p3_delta);
    if (res_wide[RES_W-1:VALUE_W-1] == '0 || res_wide[RES_W-1:VALUE_W-1] == '1) begin
      res_sat = res_wide[VALUE_W-1:0];
    end else if (res_wide[RES_W-1]) begin
      res_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    first_value = p3_flags.border ? p3_c : res_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      out_second   <= 1'b0;
    end else if (result_accept && out_second) begin
      out_second <= 1'b0;
    end else if (out_free) begin
      result_valid <= p3_valid;
      out_second   <= p3_valid && p3_flags.last_row;
    end
  end

  // last-row cells give their first result, then the passed-through border cell
  always_ff @(posedge clk) begin
    if (result_accept && out_second) begin
      new_value <= hold_d;
      run_last  <= 1'b1;
      grid_done <= hold_done;
    end else if (p3_load) begin
      new_value <= first_value;
      run_last  <= !p3_flags.last_row;
      grid_done <= 1'b0;
      hold_d    <= p3_d;
      hold_done <= p3_flags.done;
    end
  end

endmodule

// ----- rtl/heat_stencil_jacobi_step.sv -----
// heat_stencil_jacobi_step: top level, configuration registers and block wiring
// depends on hsj_pkg, hsj_front, hsj_queue and hsj_back
//
//   channel  direction  handshake            payload
//   cell     in         cell_valid/stall     cell_value
//   result   out        result_valid/stall   new_value, run_last, grid_done
//   cfg      in         cfg_valid/ready      cfg_index, cfg_data
//
// rows 0 to N-2 take one cell per cycle when nothing stalls; row N-1 is slower,
// held back by the single result register that shows both results of each such cell.
// the window a cell completes goes through stages a and b, the queue, p1 to p3 and the result register.
// each row buffer does at most one read and one write per cycle in the front end.
// the row buffers are not cleared by reset.
// a stalled result backs up through the queue into cell_stall.
module heat_stencil_jacobi_step #(
  parameter int MAX_GRID = hsj_pkg::MAX_GRID_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cell_valid,
  output logic                                 cell_stall,
  input  logic signed [hsj_pkg::VALUE_W-1:0]   cell_value,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [hsj_pkg::VALUE_W-1:0]   new_value,
  output logic                                 run_last,
  output logic                                 grid_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hsj_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [hsj_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import hsj_pkg::*;

  logic [GRID_SIZE_W-1:0] grid_size;
  logic [COEFF_W-1:0]     diffusion_coefficient;
  logic                   cfg_write;
  logic                   restart;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  window_t q_in;
  window_t q_head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write && (cfg_index == REG_GRID_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size             <= GRID_SIZE_RESET;
      diffusion_coefficient <= COEFF_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_SIZE: grid_size             <= cfg_data[GRID_SIZE_W-1:0];
        REG_COEFF:     diffusion_coefficient <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  hsj_front #(
    .MAX_GRID (MAX_GRID)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .grid_size  (grid_size),
    .restart    (restart),
    .cell_valid (cell_valid),
    .cell_value (cell_value),
    .cell_stall (cell_stall),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  hsj_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  hsj_back u_back (
    .clk          (clk),
    .rst          (rst),
    .coeff        (diffusion_coefficient),
    .q_valid      (q_valid),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .new_value    (new_value),
    .run_last     (run_last),
    .grid_done    (grid_done)
  );

`ifndef SYNTHESIS
  // grid end only ever marks the closing result of a cell
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && grid_done |-> run_last)
    else $error("grid_done without run_last");

  // a first result of a last-row cell is followed at once by its border result
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !run_last |=> result_valid && run_last)
    else $error("second result missing");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("window queue overflow");
`endif

endmodule
